// File: sv/wall_follow_mode_controller_unit_assert.svh
// assertion macros for the wall follow mode controller checker
// expects clk and rst in the scope where the macros are used
`ifndef WALL_FOLLOW_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define WALL_FOLLOW_MODE_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define WFMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wfmc assertion failed");

// next-cycle implication, disabled while in reset
`define WFMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wfmc assertion failed");

`endif

// File: sv/wfmc_pkg.sv
// types and constants shared by the wall follow mode controller modules
// no dependencies
package wfmc_pkg;

  typedef enum logic [2:0] {
    MODE_ROTATE  = 3'd0,
    MODE_FORWARD = 3'd1,
    MODE_STOP    = 3'd2,
    MODE_TURN    = 3'd3,
    MODE_WALL    = 3'd4
  } wfmc_mode_t;

  typedef enum logic [2:0] {
    REG_HALF_SPAN   = 3'd0,
    REG_FRONT_NEAR  = 3'd1,
    REG_SIDE_NEAR   = 3'd2,
    REG_STOP_TICKS  = 3'd3,
    REG_TURN_ANGLE  = 3'd4,
    REG_GOAL_WINDOW = 3'd5
  } wfmc_reg_t;

  typedef struct packed {
    logic        [12:0] prox_front;
    logic        [12:0] prox_front_left;
    logic        [12:0] prox_front_right;
    logic        [12:0] prox_side_near;
    logic        [12:0] prox_side_far;
    logic signed [15:0] goal_bearing;
    logic signed [15:0] heading;
  } wfmc_in_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic        [2:0]  mode;
  } wfmc_out_t;

  typedef struct packed {
    logic [15:0] half_span;
    logic [12:0] front_near_level;
    logic [12:0] side_near_level;
    logic [5:0]  stop_ticks;
    logic [14:0] turn_angle;
    logic [14:0] goal_window;
  } wfmc_cfg_t;

  // what the front end extracts from one sample
  typedef struct packed {
    logic        facing;
    logic        blocked;
    logic        side_gt;
    logic        side_lt;
    logic [15:0] heading;
  } wfmc_cls_t;

  // queue handshake between front and back
  typedef struct packed {
    logic empty;
    logic full;
  } wfmc_q_stat_t;

  localparam logic [15:0] RST_HALF_SPAN     = 16'd4588;
  localparam logic [12:0] RST_FRONT_NEAR    = 13'd2867;
  localparam logic [12:0] RST_SIDE_NEAR     = 13'd4096;
  localparam logic [5:0]  RST_STOP_TICKS    = 6'd20;
  localparam logic [14:0] RST_TURN_ANGLE    = 15'd15437;
  localparam logic [14:0] RST_GOAL_WINDOW   = 15'd1043;

  localparam logic [5:0] TICKS_MAX = 6'd63;

  // linear speed and rotation per mode
  localparam logic signed [5:0] V_CRUISE   = 6'sd20;
  localparam logic signed [7:0] W_ROTATE   = 8'sd50;
  localparam logic signed [7:0] W_TURN     = 8'sd100;
  localparam logic signed [7:0] W_WALL_MAG = 8'sd10;

  localparam logic signed [15:0] SPEED_FORWARD = 16'sd5120;

endpackage

// File: sv/wall_follow_mode_controller_unit.sv
// wall follow mode controller: an input beat goes into the queue on the
// accepting edge, then into the output register; one beat per cycle
// sustained while out_ready holds; mode and ticks update with the output.
// rst is synchronous: config returns to its defaults, mode to rotate,
// tick count, stored heading and last speeds to zero, queue empties.
// depends on wfmc_pkg, wfmc_front, wfmc_queue, wfmc_back
module wall_follow_mode_controller_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wfmc_pkg::wfmc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wfmc_pkg::wfmc_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  wfmc_pkg::wfmc_cfg_t    cfg;
  wfmc_pkg::wfmc_cls_t    cls_in;
  wfmc_pkg::wfmc_cls_t    cls_out;
  wfmc_pkg::wfmc_q_stat_t q_stat;
  logic                   push;
  logic                   pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_stat.full;
  assign push      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_span        <= wfmc_pkg::RST_HALF_SPAN;
      cfg.front_near_level <= wfmc_pkg::RST_FRONT_NEAR;
      cfg.side_near_level  <= wfmc_pkg::RST_SIDE_NEAR;
      cfg.stop_ticks       <= wfmc_pkg::RST_STOP_TICKS;
      cfg.turn_angle       <= wfmc_pkg::RST_TURN_ANGLE;
      cfg.goal_window      <= wfmc_pkg::RST_GOAL_WINDOW;
    end else if (cfg_valid) begin
      case (cfg_index)
        wfmc_pkg::REG_HALF_SPAN:   cfg.half_span        <= cfg_data;
        wfmc_pkg::REG_FRONT_NEAR:  cfg.front_near_level <= cfg_data[12:0];
        wfmc_pkg::REG_SIDE_NEAR:   cfg.side_near_level  <= cfg_data[12:0];
        wfmc_pkg::REG_STOP_TICKS:  cfg.stop_ticks       <= cfg_data[5:0];
        wfmc_pkg::REG_TURN_ANGLE:  cfg.turn_angle       <= cfg_data[14:0];
        wfmc_pkg::REG_GOAL_WINDOW: cfg.goal_window      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  wfmc_front u_front (
    .sample (in_data),
    .cfg    (cfg),
    .cls    (cls_in)
  );

  wfmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cls_in),
    .pop       (pop),
    .pop_data  (cls_out),
    .stat      (q_stat)
  );

  wfmc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .cls       (cls_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/wfmc_front.sv
// front end: classifies one sensor sample into the flags the mode logic needs
// depends on wfmc_pkg
module wfmc_front (
  input  wfmc_pkg::wfmc_in_t  sample,
  input  wfmc_pkg::wfmc_cfg_t cfg,
  output wfmc_pkg::wfmc_cls_t cls
);

  logic signed [16:0] win;
  logic               front_near;
  logic               fl_near;
  logic               fr_near;
  logic [13:0]        n_dist;
  logic [13:0]        f_dist;

  assign win = signed'({2'b00, cfg.goal_window});

  assign front_near = (sample.prox_front != 13'd0) && (sample.prox_front < cfg.front_near_level);
  assign fl_near    = (sample.prox_front_left != 13'd0) &&
                      (sample.prox_front_left < cfg.side_near_level);
  assign fr_near    = (sample.prox_front_right != 13'd0) &&
                      (sample.prox_front_right < cfg.side_near_level);

  // nothing seen reads as farther than any real reading
  assign n_dist = (sample.prox_side_near == 13'd0) ? 14'h2000 : {1'b0, sample.prox_side_near};
  assign f_dist = (sample.prox_side_far == 13'd0) ? 14'h2000 : {1'b0, sample.prox_side_far};

  always_comb begin
    cls.facing  = (17'(sample.goal_bearing) < win) && (17'(sample.goal_bearing) > -win);
    cls.blocked = front_near && fl_near && fr_near;
    cls.side_gt = n_dist > f_dist;
    cls.side_lt = n_dist < f_dist;
    cls.heading = sample.heading;
  end

endmodule

// File: sv/wfmc_queue.sv
// two-entry queue of classified samples between front and back
// depends on wfmc_pkg
module wfmc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  wfmc_pkg::wfmc_cls_t    push_data,
  input  logic                   pop,
  output wfmc_pkg::wfmc_cls_t    pop_data,
  output wfmc_pkg::wfmc_q_stat_t stat
);

  wfmc_pkg::wfmc_cls_t entries [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;

  assign pop_data   = entries[rd_ptr];
  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/wfmc_back.sv
// back end: mode transitions, wheel speed mix and the output register
// depends on wfmc_pkg
module wfmc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  wfmc_pkg::wfmc_cfg_t    cfg,
  input  wfmc_pkg::wfmc_q_stat_t q_stat,
  input  wfmc_pkg::wfmc_cls_t    cls,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output wfmc_pkg::wfmc_out_t    out_data
);

  wfmc_pkg::wfmc_mode_t mode;
  wfmc_pkg::wfmc_mode_t mode_next;
  logic [5:0]           ticks;
  logic [5:0]           ticks_next;
  logic [15:0]          hac;
  logic                 changed;
  logic signed [15:0]   hdg_diff;
  logic signed [5:0]    v;
  logic signed [7:0]    w;
  logic                 keep;
  logic signed [16:0]   hb_s;
  logic signed [24:0]   base;
  logic signed [24:0]   turn;
  logic signed [15:0]   left_next;
  logic signed [15:0]   right_next;

  function automatic logic signed [15:0] to_q88(input logic signed [24:0] x);
    logic signed [24:0] r;
    begin
      r = (x + 25'sd128) >>> 8;
      if (r > 25'sd32767) begin
        to_q88 = 16'sh7fff;
      end else if (r < -25'sd32768) begin
        to_q88 = 16'sh8000;
      end else begin
        to_q88 = r[15:0];
      end
    end
  endfunction

  assign pop      = !q_stat.empty && (!out_valid || out_ready);
  assign hdg_diff = signed'(cls.heading - hac);

  always_comb begin
    mode_next = mode;
    case (mode)
      wfmc_pkg::MODE_ROTATE: begin
        if (cls.facing) mode_next = wfmc_pkg::MODE_FORWARD;
      end
      wfmc_pkg::MODE_FORWARD, wfmc_pkg::MODE_WALL: begin
        if (cls.blocked) mode_next = wfmc_pkg::MODE_STOP;
      end
      wfmc_pkg::MODE_STOP: begin
        if (ticks > cfg.stop_ticks) mode_next = wfmc_pkg::MODE_TURN;
      end
      wfmc_pkg::MODE_TURN: begin
        if (hdg_diff > signed'({1'b0, cfg.turn_angle})) mode_next = wfmc_pkg::MODE_WALL;
      end
      default: mode_next = mode;
    endcase
    changed = (mode_next != mode);
    // a change restarts the count, then this tick is counted
    if (changed) begin
      ticks_next = 6'd1;
    end else if (ticks < wfmc_pkg::TICKS_MAX) begin
      ticks_next = ticks + 6'd1;
    end else begin
      ticks_next = ticks;
    end
  end

  always_comb begin
    v    = '0;
    w    = '0;
    keep = 1'b0;
    case (mode_next)
      wfmc_pkg::MODE_ROTATE:  w = wfmc_pkg::W_ROTATE;
      wfmc_pkg::MODE_FORWARD: v = wfmc_pkg::V_CRUISE;
      wfmc_pkg::MODE_STOP:    v = '0;
      wfmc_pkg::MODE_TURN:    w = wfmc_pkg::W_TURN;
      wfmc_pkg::MODE_WALL: begin
        v = wfmc_pkg::V_CRUISE;
        if (cls.side_gt) begin
          w = -wfmc_pkg::W_WALL_MAG;
        end else if (cls.side_lt) begin
          w = wfmc_pkg::W_WALL_MAG;
        end else begin
          keep = 1'b1;
        end
      end
      default: v = '0;
    endcase
  end

  assign hb_s       = signed'({1'b0, cfg.half_span});
  assign base       = signed'({{3{v[5]}}, v, 16'd0});
  assign turn       = 25'(hb_s) * 25'(w);
  assign left_next  = keep ? out_data.left_speed  : to_q88(base - turn);
  assign right_next = keep ? out_data.right_speed : to_q88(base + turn);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                 <= wfmc_pkg::MODE_ROTATE;
      ticks                <= '0;
      hac                  <= '0;
      out_valid            <= 1'b0;
      out_data.left_speed  <= '0;
      out_data.right_speed <= '0;
      out_data.mode        <= wfmc_pkg::MODE_ROTATE;
    end else begin
      if (pop) begin
        mode                 <= mode_next;
        ticks                <= ticks_next;
        if (changed) hac     <= cls.heading;
        out_valid            <= 1'b1;
        out_data.left_speed  <= left_next;
        out_data.right_speed <= right_next;
        out_data.mode        <= mode_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/wfmc_checker.sv
// port-level checks for the wall follow mode controller, bound to the top
// depends on wfmc_pkg and wall_follow_mode_controller_unit_assert.svh
`include "wall_follow_mode_controller_unit_assert.svh"

module wfmc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input wfmc_pkg::wfmc_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input wfmc_pkg::wfmc_out_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [2:0]          cfg_index,
  input logic [15:0]         cfg_data
);

  // a stalled result beat holds
  `WFMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // nothing comes out in the cycle right after reset
  `WFMC_ASSERT_NOW(a_idle_after_rst, $past(rst), !out_valid)

  // stop mode always commands standstill
  `WFMC_ASSERT_NOW(a_stop_still, out_valid && out_data.mode == wfmc_pkg::MODE_STOP, out_data.left_speed == 16'sd0 && out_data.right_speed == 16'sd0)

  // forward mode drives both wheels at cruise speed
  `WFMC_ASSERT_NOW(a_fwd_speed, out_valid && out_data.mode == wfmc_pkg::MODE_FORWARD, out_data.left_speed == wfmc_pkg::SPEED_FORWARD && out_data.right_speed == wfmc_pkg::SPEED_FORWARD)

endmodule

bind wall_follow_mode_controller_unit wfmc_checker u_wfmc_checker (.*);

// File: test/wfmc_mode_checker.sv
// checker for the wall follow mode controller: watches the sample, result and
// register channels, predicts each wheel command and compares it on arrival
// depends on wfmc_pkg
module wfmc_mode_checker
  import wfmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  wfmc_in_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  wfmc_out_t  out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int         cmd_pending,
  output int         mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  wfmc_cfg_t          regs;
  wfmc_mode_t         mode_q;
  logic [5:0]         ticks_q;
  logic [15:0]        hdg_at_change;
  logic signed [15:0] left_q;
  logic signed [15:0] right_q;

  wfmc_out_t cmd_expected[$];
  int        pending_n = 0;
  int        errs = 0;

  assign cmd_pending    = pending_n;
  assign mismatch_count = errs;

  function automatic logic signed [15:0] q88_sat(longint q16);
    longint r;
    r = (q16 + 128) >>> 8;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void set_wheels(int v, int w);
    longint base;
    longint rot;
    base = longint'(v) * 65536;
    rot  = longint'(regs.half_span) * w;
    left_q  = q88_sat(base - rot);
    right_q = q88_sat(base + rot);
  endfunction

  function automatic void enter_mode(wfmc_mode_t m, logic [15:0] hdg);
    mode_q        = m;
    ticks_q       = '0;
    hdg_at_change = hdg;
  endfunction

  function automatic bit is_near(logic [12:0] reading, logic [12:0] level);
    return reading != 0 && reading < level;
  endfunction

  function automatic wfmc_out_t next_wheel_cmd(wfmc_in_t s);
    int          win;
    int          bearing;
    int          gain;
    int          ta;
    int          n;
    int          f;
    logic [15:0] diff;
    bit          blocked;
    wfmc_out_t   o;
    win     = int'(regs.goal_window);
    bearing = int'(s.goal_bearing);
    ta      = int'(regs.turn_angle);
    blocked = is_near(s.prox_front, regs.front_near_level) &&
              is_near(s.prox_front_left, regs.side_near_level) &&
              is_near(s.prox_front_right, regs.side_near_level);

    case (mode_q)
      MODE_ROTATE: begin
        if (bearing < win && bearing > -win) enter_mode(MODE_FORWARD, s.heading);
      end
      MODE_FORWARD, MODE_WALL: begin
        if (blocked) enter_mode(MODE_STOP, s.heading);
      end
      MODE_STOP: begin
        if (ticks_q > regs.stop_ticks) enter_mode(MODE_TURN, s.heading);
      end
      MODE_TURN: begin
        diff = s.heading - hdg_at_change;
        gain = int'($signed(diff));
        if (gain > ta) enter_mode(MODE_WALL, s.heading);
      end
      default: ;
    endcase

    case (mode_q)
      MODE_ROTATE:  set_wheels(0, int'(W_ROTATE));
      MODE_FORWARD: set_wheels(int'(V_CRUISE), 0);
      MODE_STOP:    set_wheels(0, 0);
      MODE_TURN:    set_wheels(0, int'(W_TURN));
      MODE_WALL: begin
        // a zero reading means nothing seen, so it ranks beyond any real one
        n = (s.prox_side_near == 0) ? 65536 : int'(s.prox_side_near);
        f = (s.prox_side_far == 0) ? 65536 : int'(s.prox_side_far);
        if (n > f) set_wheels(int'(V_CRUISE), -int'(W_WALL_MAG));
        else if (n < f) set_wheels(int'(V_CRUISE), int'(W_WALL_MAG));
      end
      default: set_wheels(0, 0);
    endcase

    if (ticks_q < TICKS_MAX) ticks_q++;

    o.left_speed  = left_q;
    o.right_speed = right_q;
    o.mode        = mode_q;
    return o;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    wfmc_out_t want;
    if (rst) begin
      regs.half_span        = RST_HALF_SPAN;
      regs.front_near_level = RST_FRONT_NEAR;
      regs.side_near_level  = RST_SIDE_NEAR;
      regs.stop_ticks       = RST_STOP_TICKS;
      regs.turn_angle       = RST_TURN_ANGLE;
      regs.goal_window      = RST_GOAL_WINDOW;
      mode_q        = MODE_ROTATE;
      ticks_q       = '0;
      hdg_at_change = '0;
      left_q        = '0;
      right_q       = '0;
      cmd_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (wfmc_reg_t'(cfg_index))
          REG_HALF_SPAN:   regs.half_span        = cfg_data;
          REG_FRONT_NEAR:  regs.front_near_level = cfg_data[12:0];
          REG_SIDE_NEAR:   regs.side_near_level  = cfg_data[12:0];
          REG_STOP_TICKS:  regs.stop_ticks       = cfg_data[5:0];
          REG_TURN_ANGLE:  regs.turn_angle       = cfg_data[14:0];
          REG_GOAL_WINDOW: regs.goal_window      = cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) cmd_expected.push_back(next_wheel_cmd(in_data));
      if (out_valid && out_ready) begin
        if (cmd_expected.size() == 0) begin
          $display("%0t: unexpected beat, expected nothing, got %0d %0d %0d", $time,
                   out_data.left_speed, out_data.right_speed, out_data.mode);
          errs++;
        end else begin
          want = cmd_expected.pop_front();
          check_field("left_speed", int'(want.left_speed), int'(out_data.left_speed));
          check_field("right_speed", int'(want.right_speed), int'(out_data.right_speed));
          check_field("mode", int'(want.mode), int'(out_data.mode));
        end
      end
    end
    pending_n <= cmd_expected.size();
  end

endmodule

// File: test/tb.sv
// top of the wall follow mode controller testbench: clock, reset, sample and
// register stimulus, result back-pressure and the final verdict
// depends on wfmc_pkg, wall_follow_mode_controller_unit and wfmc_mode_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wfmc_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  wfmc_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  wfmc_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int cmd_pending;
  int mismatch_count;
  int n_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit held = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wall_follow_mode_controller_unit dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  wfmc_mode_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cmd_pending, .mismatch_count
  );

  function automatic wfmc_in_t sample(int front, int fleft, int fright, int snear,
                                       int sfar, int bearing, int hdg);
    wfmc_in_t s;
    s.prox_front       = 13'(front);
    s.prox_front_left  = 13'(fleft);
    s.prox_front_right = 13'(fright);
    s.prox_side_near   = 13'(snear);
    s.prox_side_far    = 13'(sfar);
    s.goal_bearing     = 16'(bearing);
    s.heading          = 16'(hdg);
    return s;
  endfunction

  function automatic logic [12:0] rand_reading();
    case ($urandom_range(0, 7))
      0:       return 13'd0;
      1:       return 13'd4096;
      default: return 13'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic wfmc_in_t rand_sample();
    wfmc_in_t s;
    s.prox_front       = rand_reading();
    s.prox_front_left  = rand_reading();
    s.prox_front_right = rand_reading();
    s.prox_side_near   = rand_reading();
    s.prox_side_far    = rand_reading();
    // obstacle close ahead, pushes forward and wall follow into stop
    if ($urandom_range(0, 99) < 18) begin
      s.prox_front       = 13'($urandom_range(1, 1500));
      s.prox_front_left  = 13'($urandom_range(1, 2500));
      s.prox_front_right = 13'($urandom_range(1, 2500));
    end
    if ($urandom_range(0, 99) < 20) s.prox_side_far = s.prox_side_near;
    if ($urandom_range(0, 99) < 35) s.goal_bearing = 16'($urandom_range(0, 3000) - 1500);
    else s.goal_bearing = 16'($urandom);
    s.heading = 16'($urandom);
    return s;
  endfunction

  task automatic send(input wfmc_in_t s);
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent <= n_sent + 1;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // stop offering samples and let every outstanding result drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cmd_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(wfmc_reg_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(wfmc_cfg_t c);
    write_reg(REG_HALF_SPAN, c.half_span);
    write_reg(REG_FRONT_NEAR, 16'(c.front_near_level));
    write_reg(REG_SIDE_NEAR, 16'(c.side_near_level));
    write_reg(REG_STOP_TICKS, 16'(c.stop_ticks));
    write_reg(REG_TURN_ANGLE, 16'(c.turn_angle));
    write_reg(REG_GOAL_WINDOW, 16'(c.goal_window));
  endtask

  // result side: changing stall styles, plus one long hold-off to back the block up
  initial begin
    int style;
    int style_left;
    int cyc;
    style      = 0;
    style_left = 0;
    cyc        = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(20, 200);
      end
      style_left--;
      if (!held && n_sent >= 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
      end else begin
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 99) < 75);
          2:       out_ready <= ($urandom_range(0, 99) < 30);
          default: out_ready <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 2000) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wfmc_cfg_t phase_regs[7];
    int        phase_items[7];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = $urandom_range(1, 40);

    // directed walk through every mode with a short stop time
    write_reg(REG_STOP_TICKS, 16'd2);
    send(sample(0, 0, 0, 0, 0, 32767, 0));
    send(sample(0, 0, 0, 0, 0, -32768, 0));
    send(sample(0, 0, 0, 0, 0, 1043, 0));        // window edge, not facing
    send(sample(0, 0, 0, 0, 0, -1042, 100));     // facing goal: forward
    send(sample(4096, 4096, 4096, 0, 0, 0, 0));  // far readings, not blocked
    send(sample(2867, 1, 1, 0, 0, 0, 0));        // front at level is not near
    send(sample(2866, 4095, 1, 0, 0, 0, 0));     // blocked: stop
    send(sample(0, 0, 0, 0, 0, 0, 0));
    send(sample(0, 0, 0, 0, 0, 0, 0));
    send(sample(0, 0, 0, 0, 0, 0, 32767));       // stop time over: turn
    send(sample(0, 0, 0, 0, 0, 0, -32768));      // heading wraps, gain of one
    send(sample(0, 0, 0, 100, 200, 0, -17330));  // gain past the turn angle: wall
    send(sample(0, 0, 0, 500, 500, 0, 0));       // equal sides keep speeds
    send(sample(0, 0, 0, 0, 4096, 0, 0));        // zero side reads as farthest
    send(sample(0, 0, 0, 4096, 0, 0, 0));
    send(sample(0, 0, 0, 0, 0, 0, 0));
    send(sample(1, 1, 1, 4096, 4096, 0, 0));     // blocked in wall follow
    send(sample(4096, 4096, 4096, 4096, 4096, 32767, 32767));

    phase_items[0] = 150;
    phase_regs[0]  = {RST_HALF_SPAN, RST_FRONT_NEAR, RST_SIDE_NEAR,
                      RST_STOP_TICKS, RST_TURN_ANGLE, RST_GOAL_WINDOW};
    phase_items[1] = 60;
    phase_regs[1]  = {16'd65535, 13'd4096, 13'd4096, 6'd63, 15'd32767, 15'd32767};
    phase_items[2] = 40;
    phase_regs[2]  = '0;
    for (int p = 3; p < 7; p++) begin
      phase_items[p] = 125;
      phase_regs[p].half_span        = 16'($urandom_range(0, 65535));
      phase_regs[p].front_near_level = 13'($urandom_range(1500, 4096));
      phase_regs[p].side_near_level  = 13'($urandom_range(2000, 4096));
      phase_regs[p].stop_ticks       = 6'($urandom_range(0, 6));
      phase_regs[p].turn_angle       = 15'($urandom_range(0, 32767));
      phase_regs[p].goal_window      = 15'($urandom_range(0, 32767));
    end

    for (int p = 0; p < 7; p++) begin
      drain();
      load_regs(phase_regs[p]);
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 0 && i == 75) drain();
        send(rand_sample());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && cmd_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
